### rtl/dwpp_pkg.sv
// ----------------------------------------------------------------------------
// dwpp_pkg: shared types and constants for the display and Wi-Fi power policy
// Holds the transaction payload structs, the configuration struct, the
// register map and the fixed time constants of the policy.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpp_pkg;

    // Event opcodes.
    localparam logic OP_ACTIVITY = 1'b0;
    localparam logic OP_EVAL     = 1'b1;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_SCHED_EN,
        REG_POWER_MODE,
        REG_ACTIVE_START,
        REG_ACTIVE_END,
        REG_TAP_WAKE,
        REG_INACT_TIMEOUT,
        REG_WIFI_ALLOWED,
        REG_CHECK_INTERVAL
    } reg_idx_t;

    localparam int PADDR_W = 5;

    // Power modes.
    localparam logic [1:0] PM_DISPLAY_ONLY = 2'd0;
    localparam logic [1:0] PM_DEEP_SLEEP   = 2'd2;

    // Time constants.
    localparam int          CUR_W         = 11;
    localparam int          DIFF_W        = 13;
    localparam int          TMO_PROD_W    = 27;
    localparam int          SLEEP_W       = 37;
    localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
    localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
    localparam logic [3:0]  MIN_SLEEP_MIN = 4'd5;
    localparam logic [15:0] MS_PER_MIN    = 16'd60000;
    localparam logic [25:0] US_PER_MIN    = 26'd60000000;

    // Configuration reset values.
    localparam logic        RST_SCHED_EN       = 1'b0;
    localparam logic [1:0]  RST_POWER_MODE     = 2'd0;
    localparam logic [10:0] RST_ACTIVE_START   = 11'd0;
    localparam logic [10:0] RST_ACTIVE_END     = 11'd0;
    localparam logic        RST_TAP_WAKE       = 1'b1;
    localparam logic [10:0] RST_INACT_TIMEOUT  = 11'd5;
    localparam logic        RST_WIFI_ALLOWED   = 1'b1;
    localparam logic [15:0] RST_CHECK_INTERVAL = 16'd1000;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        time_valid;
        logic        clock_synced;
        logic        wifi_connected;
    } evt_t;

    typedef struct packed {
        logic        display_on;
        logic        wifi_policy_off;
        logic        wifi_connect;
        logic        wifi_disconnect;
        logic        sleep_request;
        logic [36:0] sleep_us;
    } res_t;

    typedef struct packed {
        logic        schedule_enabled;
        logic [1:0]  power_mode;
        logic [10:0] active_start_minute;
        logic [10:0] active_end_minute;
        logic        tap_wake_enabled;
        logic [10:0] inactivity_timeout_minutes;
        logic        wifi_allowed;
        logic [15:0] check_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic display_flag;
        logic manual_wake;
        logic off_by_inactivity;
        logic wifi_held_off;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        display_flag:      1'b1,
        manual_wake:       1'b0,
        off_by_inactivity: 1'b0,
        wifi_held_off:     1'b0
    };

endpackage

`default_nettype wire

### rtl/dwpp_regs.sv
// ----------------------------------------------------------------------------
// dwpp_regs: configuration register file
// APB-style slave with zero wait states. Each register sits in its own
// 32-bit word; reads return the stored value, zero-extended.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpp_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dwpp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output dwpp_pkg::cfg_t                    cfg
);
    import dwpp_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Register writes on the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.schedule_enabled           <= RST_SCHED_EN;
            cfg_reg.power_mode                 <= RST_POWER_MODE;
            cfg_reg.active_start_minute        <= RST_ACTIVE_START;
            cfg_reg.active_end_minute          <= RST_ACTIVE_END;
            cfg_reg.tap_wake_enabled           <= RST_TAP_WAKE;
            cfg_reg.inactivity_timeout_minutes <= RST_INACT_TIMEOUT;
            cfg_reg.wifi_allowed               <= RST_WIFI_ALLOWED;
            cfg_reg.check_interval_ms          <= RST_CHECK_INTERVAL;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SCHED_EN:       cfg_reg.schedule_enabled           <= pwdata[0];
                REG_POWER_MODE:     cfg_reg.power_mode                 <= pwdata[1:0];
                REG_ACTIVE_START:   cfg_reg.active_start_minute        <= pwdata[10:0];
                REG_ACTIVE_END:     cfg_reg.active_end_minute          <= pwdata[10:0];
                REG_TAP_WAKE:       cfg_reg.tap_wake_enabled           <= pwdata[0];
                REG_INACT_TIMEOUT:  cfg_reg.inactivity_timeout_minutes <= pwdata[10:0];
                REG_WIFI_ALLOWED:   cfg_reg.wifi_allowed               <= pwdata[0];
                REG_CHECK_INTERVAL: cfg_reg.check_interval_ms          <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (idx)
            REG_SCHED_EN:       prdata = {31'd0, cfg_reg.schedule_enabled};
            REG_POWER_MODE:     prdata = {30'd0, cfg_reg.power_mode};
            REG_ACTIVE_START:   prdata = {21'd0, cfg_reg.active_start_minute};
            REG_ACTIVE_END:     prdata = {21'd0, cfg_reg.active_end_minute};
            REG_TAP_WAKE:       prdata = {31'd0, cfg_reg.tap_wake_enabled};
            REG_INACT_TIMEOUT:  prdata = {21'd0, cfg_reg.inactivity_timeout_minutes};
            REG_WIFI_ALLOWED:   prdata = {31'd0, cfg_reg.wifi_allowed};
            REG_CHECK_INTERVAL: prdata = {16'd0, cfg_reg.check_interval_ms};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/dwpp_eval.sv
// ----------------------------------------------------------------------------
// dwpp_eval: single-event policy step
// Combinational next-state and result logic for one event: activity stamp,
// manual wake, inactivity timeout, schedule window, Wi-Fi hold and sleep.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpp_eval #(
    parameter int STAMP_WIDTH = 32
) (
    input  wire dwpp_pkg::evt_t        evt,
    input  wire dwpp_pkg::cfg_t        cfg,
    input  wire dwpp_pkg::flags_t      flags,
    input  wire logic [STAMP_WIDTH-1:0] last_act,
    input  wire logic [STAMP_WIDTH-1:0] last_chk,
    output dwpp_pkg::flags_t           flags_next,
    output logic      [STAMP_WIDTH-1:0] last_act_next,
    output logic      [STAMP_WIDTH-1:0] last_chk_next,
    output dwpp_pkg::res_t             res
);
    import dwpp_pkg::*;

    localparam int CMP_W = (STAMP_WIDTH > TMO_PROD_W) ? STAMP_WIDTH : TMO_PROD_W;

    logic [STAMP_WIDTH-1:0] now_s;
    logic [STAMP_WIDTH-1:0] idle;
    logic [STAMP_WIDTH-1:0] since;
    logic [TMO_PROD_W-1:0]  tmo_ms;
    logic                   timeout_hit;
    logic                   interval_hit;
    logic [CUR_W-1:0]       cur;
    logic                   in_win;
    logic [DIFF_W-1:0]      diff;
    logic                   diff_ok;
    logic [CUR_W-1:0]       diff_m1;
    logic [SLEEP_W-1:0]     sleep_len;
    logic                   mode_wifi;
    logic                   done;
    flags_t                 f;

    // Stamp arithmetic wraps at the stamp width.
    assign now_s        = STAMP_WIDTH'(evt.now_ms);
    assign idle         = now_s - last_act;
    assign since        = now_s - last_chk;
    assign tmo_ms       = TMO_PROD_W'(cfg.inactivity_timeout_minutes)
                        * TMO_PROD_W'(MS_PER_MIN);
    assign timeout_hit  = CMP_W'(idle) > CMP_W'(tmo_ms);
    assign interval_hit = since >= STAMP_WIDTH'(cfg.check_interval_ms);

    // Minute of day and active window test; the window may wrap past midnight.
    assign cur = CUR_W'(CUR_W'(evt.hour) * MIN_PER_HOUR) + CUR_W'(evt.minute);

    always_comb
    begin
        if (cfg.active_start_minute == cfg.active_end_minute)
            in_win = 1'b1;
        else if (cfg.active_start_minute < cfg.active_end_minute)
            in_win = (cur >= cfg.active_start_minute) && (cur < cfg.active_end_minute);
        else
            in_win = (cur >= cfg.active_start_minute) || (cur < cfg.active_end_minute);
    end

    // Minutes until the window opens again; may go negative for odd inputs.
    always_comb
    begin
        if (cfg.active_start_minute > cur)
            diff = DIFF_W'(cfg.active_start_minute) - DIFF_W'(cur);
        else
            diff = DIFF_W'(MIN_PER_DAY) - DIFF_W'(cur) + DIFF_W'(cfg.active_start_minute);
    end

    assign diff_ok   = $signed(diff) >= $signed(DIFF_W'(MIN_SLEEP_MIN));
    assign diff_m1   = CUR_W'(diff - DIFF_W'(1));
    assign sleep_len = SLEEP_W'(diff_m1) * SLEEP_W'(US_PER_MIN);
    assign mode_wifi = cfg.power_mode != PM_DISPLAY_ONLY;

    // Policy step.
    always_comb
    begin
        f             = flags;
        done          = 1'b0;
        last_act_next = last_act;
        last_chk_next = last_chk;
        res           = '0;

        if (evt.op == OP_ACTIVITY)
        begin
            last_act_next = now_s;
            if (cfg.tap_wake_enabled && !f.display_flag)
            begin
                f.manual_wake       = 1'b1;
                f.off_by_inactivity = 1'b0;
            end
        end
        else
        begin
            // A pending manual wake lights the display first.
            if (f.manual_wake && !f.display_flag)
            begin
                f.display_flag      = 1'b1;
                f.off_by_inactivity = 1'b0;
            end

            // Inactivity timeout ends the step when it fires.
            if (f.display_flag && (last_act != '0) && timeout_hit)
            begin
                f.display_flag      = 1'b0;
                f.off_by_inactivity = 1'b1;
                f.manual_wake       = 1'b0;
                done                = 1'b1;
            end

            if (!done && interval_hit)
            begin
                last_chk_next = now_s;
                if (!cfg.schedule_enabled)
                begin
                    if (f.wifi_held_off)
                    begin
                        f.wifi_held_off  = 1'b0;
                        res.wifi_connect = cfg.wifi_allowed && !evt.wifi_connected;
                    end
                end
                else if (evt.time_valid)
                begin
                    // Wi-Fi hold outside the window in a Wi-Fi power mode, release otherwise.
                    if (!in_win && mode_wifi)
                    begin
                        if (!f.wifi_held_off)
                        begin
                            f.wifi_held_off     = 1'b1;
                            res.wifi_disconnect = 1'b1;
                        end
                    end
                    else if (f.wifi_held_off)
                    begin
                        f.wifi_held_off  = 1'b0;
                        res.wifi_connect = cfg.wifi_allowed && !evt.wifi_connected;
                    end

                    // Display follows the window unless the timeout or a manual wake owns it.
                    if (!f.off_by_inactivity)
                    begin
                        if (!in_win && !f.manual_wake)
                            f.display_flag = 1'b0;
                        else if (in_win)
                        begin
                            f.display_flag = 1'b1;
                            f.manual_wake  = 1'b0;
                        end
                    end

                    // Deep sleep until one minute before the window opens.
                    if (!in_win && (cfg.power_mode == PM_DEEP_SLEEP) && evt.clock_synced
                        && !f.manual_wake && diff_ok)
                    begin
                        res.sleep_request   = 1'b1;
                        res.wifi_disconnect = 1'b1;
                        res.sleep_us        = sleep_len;
                    end
                end
            end
        end

        flags_next          = f;
        res.display_on      = f.display_flag;
        res.wifi_policy_off = f.wifi_held_off;
    end

endmodule

`default_nettype wire

### rtl/display_wifi_power_policy.sv
// ----------------------------------------------------------------------------
// display_wifi_power_policy: display and Wi-Fi power policy controller
// Takes activity and evaluation events and returns one policy result per
// event: display and Wi-Fi hold state plus connect, disconnect and sleep.
//
//   Channel   Handshake             Payload   Direction
//   evt       evt_valid/evt_ready   evt_t     event in
//   res       res_valid/res_ready   res_t     result out
//   apb       psel/penable/pready   32-bit    configuration
//
// Each event is captured in the input register and its result is registered
// in the result register; one event per cycle is sustained while results are
// taken. The policy step is one pass of logic between the two.
// A stalled result holds the result register; the input register keeps
// accepting as long as its contents can move on in the same cycle.
// Reset turns the display flag on, clears the other policy flags, both
// stamps and the valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module display_wifi_power_policy #(
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         evt_valid,
    output logic                              evt_ready,
    input  wire dwpp_pkg::evt_t               evt,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output dwpp_pkg::res_t                    res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dwpp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import dwpp_pkg::*;

    cfg_t                   cfg;
    logic                   in_valid_reg;
    evt_t                   in_data_reg;
    logic                   out_valid_reg;
    res_t                   out_data_reg;
    flags_t                 flags_reg;
    flags_t                 flags_next;
    logic [STAMP_WIDTH-1:0] last_act_reg;
    logic [STAMP_WIDTH-1:0] last_act_next;
    logic [STAMP_WIDTH-1:0] last_chk_reg;
    logic [STAMP_WIDTH-1:0] last_chk_next;
    res_t                   step_res;
    logic                   advance;

    dwpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dwpp_eval #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_eval (
        .evt           (in_data_reg),
        .cfg           (cfg),
        .flags         (flags_reg),
        .last_act      (last_act_reg),
        .last_chk      (last_chk_reg),
        .flags_next    (flags_next),
        .last_act_next (last_act_next),
        .last_chk_next (last_chk_next),
        .res           (step_res)
    );

    // An event moves to the result register when that register frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign evt_ready = !in_valid_reg || advance;
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // Control state and policy state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FLAGS_RESET;
            last_act_reg  <= '0;
            last_chk_reg  <= '0;
        end
        else
        begin
            if (evt_ready)
                in_valid_reg <= evt_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                flags_reg    <= flags_next;
                last_act_reg <= last_act_next;
                last_chk_reg <= last_chk_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
            in_data_reg <= evt;
        if (advance)
            out_data_reg <= step_res;
    end

`ifndef SYNTH
    // A sleep request always comes with a Wi-Fi disconnect.
    a_sleep_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.sleep_request) |-> out_data_reg.wifi_disconnect)
        else $error("sleep request without wifi disconnect");

    // The sleep length is zero unless sleep is requested.
    a_sleep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.sleep_request) |-> (out_data_reg.sleep_us == '0))
        else $error("sleep length set without sleep request");

    // A connect pulse only follows a release of the Wi-Fi hold.
    a_conn_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.wifi_connect)
        |-> (!out_data_reg.wifi_policy_off && !out_data_reg.wifi_disconnect))
        else $error("wifi connect while held off");

    // A disconnect without sleep means the hold was just taken.
    a_disc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.wifi_disconnect && !out_data_reg.sleep_request)
        |-> out_data_reg.wifi_policy_off)
        else $error("wifi disconnect without hold");

    // An event that moves on always shows up as a result next cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");
`endif

endmodule

`default_nettype wire
